[hw/rtl/ppa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppa_pkg
// Types and constants shared by the page permission auditor: the transaction
// payloads, opcodes, register map and address arithmetic constants.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned DefaultMaxSections = 32;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LABEL_W = 64;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // page size, in the 33-bit end arithmetic
  localparam logic [ADDR_W:0] PAGE_BYTES = 33'h0_0000_1000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SECTION_COUNT = 1'b0;

  typedef struct packed {
    logic               operation;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  section_size;
    logic               section_write;
    logic               section_exec;
    logic [LABEL_W-1:0] section_label;
    logic               page_mapped;
    logic               pte_writable;
    logic               pte_executable;
    logic               pte_large;
    logic               pte_user;
  } item_t;

  typedef struct packed {
    logic               expect_known;
    logic               expect_write;
    logic               expect_exec;
    logic               straddles;
    logic [LABEL_W-1:0] match_label;
    logic               flag_not_mapped;
    logic               flag_wx_large;
    logic               flag_wx_small;
    logic               flag_user;
    logic               flag_write;
    logic               flag_execute;
    logic               flag_not_exec;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/page_permission_auditor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_permission_auditor
// Section table with a pipelined page check: range match over all slots,
// first-match select with attribute read, then permission mismatch flags.
//
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------
// item      | start / busy               | item_i   (ppa_pkg::item_t)
// result    | result_valid_o (strobe)    | result_o (ppa_pkg::result_t)
// config    | apb psel/penable/pready    | paddr / pwdata / prdata
//
// one transaction per cycle; busy stays low, the pipeline never stalls
// a check result is registered through s1, s2 and s3 and strobes from result_q
// stages: range compare, first-match select and attribute read, flag logic
// loads give no result and update the table for every later check
// reset clears section_count and the valid bits; the table is not cleared
// ----------------------------------------------------------------------------
module page_permission_auditor #(
  parameter int unsigned MAX_SECTIONS = ppa_pkg::DefaultMaxSections
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ppa_pkg::item_t                item_i,
  output logic                               result_valid_o,
  output ppa_pkg::result_t                   result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppa_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ppa_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppa_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import ppa_pkg::*;

  localparam int unsigned IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned EXT_W  = 7;
  localparam int unsigned ATTR_W = LABEL_W + 2;

  typedef struct packed {
    logic mapped;
    logic writable;
    logic executable;
    logic huge;
    logic user;
  } pte_t;

  // configuration
  logic [CNT_W-1:0] section_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SECTION_COUNT);
  assign prdata = (paddr[2] == REG_SECTION_COUNT) ? PDATA_W'(section_count_q) : '0;
  assign busy   = 1'b0;

  // input side
  logic             accept;
  logic             load_wr;
  logic [EXT_W-1:0] slot_ext;
  logic [IDX_W-1:0] slot_idx;

  assign accept   = start && !busy;
  assign slot_ext = EXT_W'(item_i.slot);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign load_wr  = accept && (item_i.operation == OP_LOAD)
                    && (slot_ext < EXT_W'(MAX_SECTIONS));

  // range table, compared at every slot in parallel
  logic [ADDR_W-1:0] start_q [MAX_SECTIONS];
  logic [ADDR_W-1:0] len_q   [MAX_SECTIONS];

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      start_q[slot_idx] <= item_i.address;
      len_q[slot_idx]   <= item_i.section_size;
    end
  end

  // attribute memory {exec, write, label}, written in the cycle after the load
  logic [ATTR_W-1:0] attr_mem [MAX_SECTIONS];
  logic              wr_pend_q;
  logic [IDX_W-1:0]  wr_idx_q;
  logic [ATTR_W-1:0] wr_data_q;
  logic [IDX_W-1:0]  win_idx;
  logic [ATTR_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    wr_idx_q  <= slot_idx;
    wr_data_q <= {item_i.section_exec, item_i.section_write, item_i.section_label};
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      attr_mem[wr_idx_q] <= wr_data_q;
    end
    rd_q <= attr_mem[win_idx];
  end

  // pipeline registers
  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic [ADDR_W-1:0]       s1_addr_q;
  pte_t                    s1_pte_q, s2_pte_q, s3_pte_q;
  logic [MAX_SECTIONS-1:0] hit_d, strad_d, s2_hit_q, s2_strad_q;
  logic                    known_d, strad_sel_d, s3_known_q, s3_strad_q;
  result_t                 result_d, result_q;
  logic                    result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_count_q <= '0;
      wr_pend_q       <= 1'b0;
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
      s3_valid_q      <= 1'b0;
      result_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        section_count_q <= pwdata[CNT_W-1:0];
      end
      wr_pend_q      <= load_wr;
      s1_valid_q     <= accept && (item_i.operation == OP_CHECK);
      s2_valid_q     <= s1_valid_q;
      s3_valid_q     <= s2_valid_q;
      result_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= item_i.address;
    s1_pte_q   <= '{mapped:     item_i.page_mapped,
                    writable:   item_i.pte_writable,
                    executable: item_i.pte_executable,
                    huge:       item_i.pte_large,
                    user:       item_i.pte_user};
    s2_hit_q   <= hit_d;
    s2_strad_q <= strad_d;
    s2_pte_q   <= s1_pte_q;
    s3_known_q <= known_d;
    s3_strad_q <= strad_sel_d;
    s3_pte_q   <= s2_pte_q;
    result_q   <= result_d;
  end

  // stage 1: range compare against every slot
  always_comb begin
    logic [ADDR_W:0] a_base;
    logic [ADDR_W:0] a_end;
    logic [ADDR_W:0] lo;
    logic [ADDR_W:0] hi;
    a_base = {1'b0, s1_addr_q};
    a_end  = a_base + PAGE_BYTES;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      lo         = {1'b0, start_q[i]};
      hi         = lo + {1'b0, len_q[i]};
      hit_d[i]   = (EXT_W'(i) < EXT_W'(section_count_q)) && (a_base >= lo) && (a_base < hi);
      strad_d[i] = a_end > hi;
    end
  end

  // stage 2: first match, attribute read address
  always_comb begin
    logic [MAX_SECTIONS-1:0] first;
    first   = s2_hit_q & (~s2_hit_q + MAX_SECTIONS'(1));
    win_idx = '0;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (first[i]) begin
        win_idx = win_idx | IDX_W'(i);
      end
    end
    known_d     = |s2_hit_q;
    strad_sel_d = |(first & s2_strad_q);
  end

  // stage 3: expectation and mismatch flags
  always_comb begin
    logic exp_w;
    logic exp_x;
    logic chk;
    exp_w    = s3_known_q && rd_q[LABEL_W];
    exp_x    = s3_known_q && rd_q[LABEL_W+1];
    chk      = s3_known_q && !s3_strad_q && !s3_pte_q.huge;
    result_d = '0;
    if (!s3_pte_q.mapped) begin
      result_d.flag_not_mapped = 1'b1;
    end else begin
      result_d.expect_known  = s3_known_q;
      result_d.expect_write  = exp_w;
      result_d.expect_exec   = exp_x;
      result_d.straddles     = s3_known_q && s3_strad_q;
      result_d.match_label   = s3_known_q ? rd_q[LABEL_W-1:0] : '0;
      result_d.flag_wx_large = s3_pte_q.writable && s3_pte_q.executable && s3_pte_q.huge;
      result_d.flag_wx_small = s3_pte_q.writable && s3_pte_q.executable && !s3_pte_q.huge;
      result_d.flag_user     = s3_pte_q.user;
      result_d.flag_write    = chk && s3_pte_q.writable && !exp_w;
      result_d.flag_execute  = chk && s3_pte_q.executable && !exp_x;
      result_d.flag_not_exec = chk && !s3_pte_q.executable && exp_x;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page permission auditor. A short table of
// directed loads, checks and section_count writes comes first, then phases of
// random section loads and page checks under three sender idle rates. Every
// check result is compared field by field against a written expectation or
// an in-bench section table model, oldest expectation first.
// ----------------------------------------------------------------------------
module tb_top;
  import ppa_pkg::*;

  localparam int unsigned NumSlots = DefaultMaxSections;

  typedef enum logic [1:0] {ROW_LOAD, ROW_CHECK, ROW_COUNT} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    item_t       item;
    logic [31:0] count_val;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  item_t                item_i;
  logic                 result_valid_o;
  result_t              result_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic [ADDR_W-1:0]  sect_base [NumSlots];
  logic [ADDR_W-1:0]  sect_size [NumSlots];
  logic               sect_wr   [NumSlots];
  logic               sect_ex   [NumSlots];
  logic [LABEL_W-1:0] sect_tag  [NumSlots];
  logic [CNT_W-1:0]   live_count;

  result_t  pending_audits [$];
  dir_row_t dir_rows [$];
  result_t  want_r;
  int       mismatches;

  page_permission_auditor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic item_t load_item(logic [4:0] slot, logic [31:0] base, logic [31:0] size,
                                      logic w, logic x, logic [63:0] tag);
    item_t it;
    it.operation      = OP_LOAD;
    it.slot           = slot;
    it.address        = base;
    it.section_size   = size;
    it.section_write  = w;
    it.section_exec   = x;
    it.section_label  = tag;
    it.page_mapped    = 1'($urandom);
    it.pte_writable   = 1'($urandom);
    it.pte_executable = 1'($urandom);
    it.pte_large      = 1'($urandom);
    it.pte_user       = 1'($urandom);
    return it;
  endfunction

  function automatic item_t check_item(logic [31:0] addr, logic mapped, logic w, logic x,
                                       logic lg, logic us);
    item_t it;
    it.operation      = OP_CHECK;
    it.slot           = 5'($urandom);
    it.address        = addr;
    it.section_size   = $urandom;
    it.section_write  = 1'($urandom);
    it.section_exec   = 1'($urandom);
    it.section_label  = {$urandom, $urandom};
    it.page_mapped    = mapped;
    it.pte_writable   = w;
    it.pte_executable = x;
    it.pte_large      = lg;
    it.pte_user       = us;
    return it;
  endfunction

  function automatic result_t flags_only(logic nm, logic wl, logic ws, logic us);
    result_t r;
    r                 = '0;
    r.flag_not_mapped = nm;
    r.flag_wx_large   = wl;
    r.flag_wx_small   = ws;
    r.flag_user       = us;
    return r;
  endfunction

  // first valid section holding the page, then the permission mismatch bits
  function automatic result_t audit_page(item_t it);
    result_t     r;
    int unsigned n;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] a;
    r = '0;
    if (!it.page_mapped) begin
      r.flag_not_mapped = 1'b1;
      return r;
    end
    n = (live_count > NumSlots) ? NumSlots : live_count;
    a = {1'b0, it.address};
    for (int i = 0; i < n; i++) begin
      lo = {1'b0, sect_base[i]};
      hi = lo + {1'b0, sect_size[i]};
      if (!r.expect_known && a >= lo && a < hi) begin
        r.expect_known = 1'b1;
        r.expect_write = sect_wr[i];
        r.expect_exec  = sect_ex[i];
        r.match_label  = sect_tag[i];
        r.straddles    = (a + PAGE_BYTES) > hi;
      end
    end
    if (it.pte_writable && it.pte_executable) begin
      if (it.pte_large) r.flag_wx_large = 1'b1;
      else              r.flag_wx_small = 1'b1;
    end
    r.flag_user = it.pte_user;
    if (r.expect_known && !r.straddles && !it.pte_large) begin
      r.flag_write    = it.pte_writable && !r.expect_write;
      r.flag_execute  = it.pte_executable && !r.expect_exec;
      r.flag_not_exec = !it.pte_executable && r.expect_exec;
    end
    return r;
  endfunction

  function automatic bit same_result(result_t a, result_t b);
    return a.expect_known === b.expect_known && a.expect_write === b.expect_write &&
           a.expect_exec === b.expect_exec && a.straddles === b.straddles &&
           a.match_label === b.match_label && a.flag_not_mapped === b.flag_not_mapped &&
           a.flag_wx_large === b.flag_wx_large && a.flag_wx_small === b.flag_wx_small &&
           a.flag_user === b.flag_user && a.flag_write === b.flag_write &&
           a.flag_execute === b.flag_execute && a.flag_not_exec === b.flag_not_exec;
  endfunction

  function automatic item_t make_section(logic [4:0] slot);
    logic [31:0] base;
    logic [31:0] size;
    case ($urandom_range(0, 9))
      0: begin
        base = $urandom;
        size = $urandom;
      end
      1: begin
        base = 32'h8000_0000 + ($urandom_range(0, 15) << 12);
        size = 32'h2000_0000;
      end
      2: begin
        base = 32'hFFFF_F000 - ($urandom_range(0, 7) << 12);
        size = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : ($urandom_range(1, 9) << 12);
      end
      3: begin
        base = $urandom_range(0, 63) << 12;
        size = '0;
      end
      default: begin
        base = ($urandom_range(0, 63) << 12) |
               (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0);
        size = ($urandom_range(1, 8) << 12) +
               (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0);
      end
    endcase
    return load_item(slot, base, size, 1'($urandom), 1'($urandom), {$urandom, $urandom});
  endfunction

  function automatic item_t make_page_check();
    int unsigned j;
    logic [31:0] off;
    logic [31:0] addr;
    j = $urandom_range(0, NumSlots - 1);
    if ($urandom_range(0, 3) == 0) begin
      addr = $urandom;
    end else if (sect_size[j] == 0) begin
      addr = sect_base[j];
    end else begin
      if ($urandom_range(0, 1) != 0) begin
        off = $urandom % sect_size[j];
      end else begin
        off = $urandom_range(0, 32'h1FFF);
        off = (off >= sect_size[j]) ? '0 : sect_size[j] - 1 - off;
      end
      addr = sect_base[j] + off;
    end
    return check_item(addr, $urandom_range(0, 9) != 0, 1'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom));
  endfunction

  task automatic add_row(row_kind_e k, item_t it, logic [31:0] cnt, bit typed, result_t want);
    dir_row_t row;
    row.kind      = k;
    row.item      = it;
    row.count_val = cnt;
    row.typed     = typed;
    row.want      = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(item_t it, int unsigned idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic note_item(item_t it);
    if (it.operation == OP_CHECK) begin
      pending_audits.push_back(audit_page(it));
    end else if (it.slot < NumSlots) begin
      sect_base[it.slot] = it.address;
      sect_size[it.slot] = it.section_size;
      sect_wr[it.slot]   = it.section_write;
      sect_ex[it.slot]   = it.section_exec;
      sect_tag[it.slot]  = it.section_label;
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_audits.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_count(logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SECTION_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    live_count  = value[CNT_W-1:0];
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_audits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", result_o);
      end else begin
        want_r = pending_audits.pop_front();
        if (!same_result(want_r, result_o)) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %h actual %h", want_r,
                                         result_o);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned idle_pct;
    logic [31:0] cnt_word;
    logic [5:0]  phase_counts [12];
    item_t       it;
    phase_counts = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd32,
                     6'd16, 6'd40, 6'd32, 6'd5, 6'd63, 6'd32};
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    live_count = '0;
    mismatches = 0;
    for (int i = 0; i < NumSlots; i++) begin
      sect_base[i] = '0;
      sect_size[i] = '0;
      sect_wr[i]   = 1'b0;
      sect_ex[i]   = 1'b0;
      sect_tag[i]  = '0;
    end

    // empty table: only the page flags can fire
    add_row(ROW_CHECK, check_item(32'h0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1), 0, 1,
            flags_only(1'b1, 1'b0, 1'b0, 1'b0));
    add_row(ROW_CHECK, check_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 0, 1,
            flags_only(1'b0, 1'b1, 1'b0, 1'b1));
    add_row(ROW_CHECK, check_item(32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 0, 1,
            flags_only(1'b0, 1'b0, 1'b1, 1'b0));
    add_row(ROW_CHECK, check_item(32'h2000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 0, 1,
            flags_only(1'b0, 1'b0, 1'b0, 1'b0));
    add_row(ROW_LOAD, load_item(5'd0, 32'h1000, 32'h3000, 1'b0, 1'b1,
                                64'h0000_0074_7865_742E), 0, 0, '0);
    add_row(ROW_LOAD, load_item(5'd1, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, '1), 0, 0, '0);
    add_row(ROW_LOAD, load_item(5'd2, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                64'h0000_6174_6164_2E), 0, 0, '0);
    add_row(ROW_LOAD, load_item(5'd3, 32'h5000, 32'h0, 1'b1, 1'b1, 64'h1), 0, 0, '0);
    add_row(ROW_LOAD, load_item(5'd31, 32'h8000_0000, 32'h2000_0000, 1'b0, 1'b0,
                                64'h8000_0000_0000_0000), 0, 0, '0);
    add_row(ROW_COUNT, '0, 32'd4, 0, '0);
    add_row(ROW_CHECK, check_item(32'h1000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'h3800, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'h2FFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'h5000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'hFFFF_F000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1), 0, 0, '0);
    add_row(ROW_COUNT, '0, 32'd1, 0, '0);
    add_row(ROW_CHECK, check_item(32'h4000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 0, 0, '0);
    add_row(ROW_CHECK, check_item(32'h3FFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0), 0, 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_COUNT) begin
        write_count(dir_rows[k].count_val);
      end else begin
        send_item(dir_rows[k].item, 0);
        if (dir_rows[k].typed) pending_audits.push_back(dir_rows[k].want);
        else note_item(dir_rows[k].item);
      end
    end

    // fill every slot so any section_count is legal from here on
    for (int s = 0; s < NumSlots; s++) begin
      it = make_section(5'(s));
      send_item(it, 33);
      note_item(it);
    end

    for (int p = 0; p < 12; p++) begin
      idle_pct = (p < 4) ? 33 : (p < 8) ? 83 : 0;
      cnt_word = {26'($urandom), phase_counts[p]};
      if (p % 2 == 0) cnt_word[31:CNT_W] = '0;
      write_count(cnt_word);
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(0, 9) == 0) it = make_section(5'($urandom));
        else it = make_page_check();
        send_item(it, idle_pct);
        note_item(it);
      end
    end

    start <= 1'b0;
    for (int w = 0; w < 2000 && pending_audits.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_audits.size() != 0) begin
      mismatches += pending_audits.size();
      $display("%0d expected results never arrived", pending_audits.size());
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
